/* src/assert_macros.svh */
// assertion helpers for the rtl, included by tlpc_seq; clock clk, reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at this edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/tlpc_pkg.sv */
// ----------------------------------------------------------------------------
// tlpc_pkg
// types, constants and helper functions of the traffic light phase controller
// ----------------------------------------------------------------------------
package tlpc_pkg;

	// request kinds
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_LONGER  = 2'd1;
	localparam logic [1:0] KIND_SHORTER = 2'd2;

	// register indexes
	localparam logic [1:0] REG_TPS      = 2'd0;
	localparam logic [1:0] REG_AMBER    = 2'd1;
	localparam logic [1:0] REG_WALK_OFF = 2'd2;

	localparam logic [7:0] RESET_TPS      = 8'd20;
	localparam logic [3:0] RESET_AMBER    = 4'd3;
	localparam logic [6:0] RESET_WALK_OFF = 7'd10;
	localparam logic [6:0] MIN_PERIOD     = 7'd10;

	// lamp port patterns
	localparam logic [7:0] MAIN_AMBER_R1 = 8'h84;
	localparam logic [7:0] AUX_AMBER_R1  = 8'h81;
	localparam logic [7:0] MAIN_AMBER_R0 = 8'h48;
	localparam logic [7:0] AUX_AMBER_R0  = 8'h02;
	localparam logic [7:0] MAIN_ARROW_R1 = 8'h89;
	localparam logic [7:0] AUX_ARROW_R1  = 8'h80;
	localparam logic [7:0] MAIN_PLAIN_R1 = 8'h82;
	localparam logic [7:0] AUX_PLAIN_R1  = 8'h81;
	localparam logic [7:0] MAIN_ARROW_R0 = 8'h98;
	localparam logic [7:0] AUX_ARROW_R0  = 8'h00;
	localparam logic [7:0] MAIN_PLAIN_R0 = 8'h28;
	localparam logic [7:0] AUX_PLAIN_R0  = 8'h02;

	localparam int RESULT_W = 72;

	typedef struct packed {
		logic [7:0] tps;
		logic [3:0] amber_s;
		logic [6:0] walk_off;
	} tlpc_cfg_t;

	typedef struct packed {
		logic [7:0] subtick;
		logic [6:0] elapsed;
		logic [6:0] active_period;
		logic [6:0] next_period;
		logic [6:0] phase_cnt;
		logic [6:0] walk_cnt;
		logic       road;
		logic       amber;
		logic       arrow;
	} tlpc_state_t;

	// seven-segment code, gfedcba
	function automatic logic [6:0] seg7(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h3F;
		endcase
		return s;
	endfunction

	// v / 10 by reciprocal multiply, exact for every 7-bit value
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [6:0] seg_tens(input logic [6:0] v);
		logic [3:0] q;
		q = div10(v);
		return seg7((q >= 4'd10) ? q - 4'd10 : q);
	endfunction

	function automatic logic [6:0] seg_units(input logic [6:0] v);
		logic [6:0] r;
		r = v - 7'(div10(v) * 7'd10);
		return seg7(r[3:0]);
	endfunction

endpackage

/* src/traffic_light_phase_controller.sv */
// ----------------------------------------------------------------------------
// traffic_light_phase_controller
// two-road light sequencer stepped by tick and button requests
// ----------------------------------------------------------------------------
// usage:
//   s_* carries requests: tuser is the kind (tick, lengthen, shorten),
//   tdata bit 0 is the pause-held flag. every request gives one result on m_*
//   showing the state after it: lamp patterns, direction, amber and arrow
//   flags, both countdowns, their seven-segment digits and the pending period.
//   m_tvalid rises once the request has passed the input register and its state
//   update has been written into the result register. one request per cycle is
//   sustained while m_tready stays high; the state update loop sets that rate.
//   a stalled m_tready holds the result; the input register still takes one
//   more request, after which s_tready drops until the result is taken.
//   reset loads the default period on the phase timer, road 1 green, and
//   the register defaults (20 ticks per second, 3 s amber, walk offset 10).
//   the user writes registers over apb at 0x0, 0x4, 0x8 only while no request is
//   in flight (not enforced by the block); they act from the next request.
// ----------------------------------------------------------------------------
module traffic_light_phase_controller
	import tlpc_pkg::*;
#(
	parameter logic [6:0] DEFAULT_PERIOD = 7'd20,
	parameter logic [6:0] MAX_PERIOD     = 7'd99
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // held[0], zeros[7:1]
	input  logic [1:0]           s_tuser,  // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// main_lamps[7:0], aux_lamps[15:8], direction[16], amber_on[17], arrow_on[18],
	// seconds_left[25:19], walk_left[32:26], seg_time_tens[39:33],
	// seg_time_units[46:40], seg_walk_tens[53:47], seg_walk_units[60:54],
	// pending_period[67:61], zeros[71:68]
	output logic [RESULT_W-1:0]  m_tdata
);

	tlpc_cfg_t           cfg;
	tlpc_state_t         st_nx;
	logic [RESULT_W-1:0] res_data;
	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic                held_s1;
	logic                m_valid_q;
	logic [RESULT_W-1:0] m_data_q;
	logic                advance;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	tlpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlpc_seq #(
		.DefaultPeriod (DEFAULT_PERIOD),
		.MaxPeriod     (MAX_PERIOD)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.kind   (kind_s1),
		.held   (held_s1),
		.cfg    (cfg),
		.st_nx  (st_nx)
	);

	tlpc_fmt u_fmt (
		.st   (st_nx),
		.data (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			held_s1 <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_data_q <= res_data;
	end

endmodule

/* src/tlpc_regs.sv */
// ----------------------------------------------------------------------------
// tlpc_regs
// apb register file: tick rate, amber lead time, walk offset
// ----------------------------------------------------------------------------
module tlpc_regs
	import tlpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output tlpc_cfg_t   cfg
);

	tlpc_cfg_t  cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tps      <= RESET_TPS;
			cfg_q.amber_s  <= RESET_AMBER;
			cfg_q.walk_off <= RESET_WALK_OFF;
		end else if (wr_en) begin
			unique case (idx)
				REG_TPS:      cfg_q.tps      <= pwdata[7:0];
				REG_AMBER:    cfg_q.amber_s  <= pwdata[3:0];
				REG_WALK_OFF: cfg_q.walk_off <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TPS:      prdata = {24'd0, cfg_q.tps};
			REG_AMBER:    prdata = {28'd0, cfg_q.amber_s};
			REG_WALK_OFF: prdata = {25'd0, cfg_q.walk_off};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

/* src/tlpc_seq.sv */
// ----------------------------------------------------------------------------
// tlpc_seq
// phase state registers and the per-request update
// ----------------------------------------------------------------------------
module tlpc_seq
	import tlpc_pkg::*;
#(
	parameter logic [6:0] DefaultPeriod = 7'd20,
	parameter logic [6:0] MaxPeriod     = 7'd99
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [1:0]  kind,
	input  logic        held,
	input  tlpc_cfg_t   cfg,
	output tlpc_state_t st_nx
);
	`include "assert_macros.svh"

	localparam logic [6:0] ResetWalk =
		(DefaultPeriod > RESET_WALK_OFF) ? DefaultPeriod - RESET_WALK_OFF : 7'd0;

	tlpc_state_t st_q;
	logic [8:0]  sub_inc;
	logic        boundary;
	logic [6:0]  amb7;

	assign sub_inc  = {1'b0, st_q.subtick} + 9'd1;
	assign boundary = sub_inc >= {1'b0, cfg.tps};
	assign amb7     = {3'd0, cfg.amber_s};

	always_comb begin
		logic [6:0] half;
		st_nx = st_q;
		half  = 7'd0;
		if (step) begin
			case (kind)
				KIND_TICK: begin
					if (!held) begin
						st_nx.subtick = boundary ? 8'd0 : sub_inc[7:0];
						if (boundary) begin
							st_nx.elapsed = st_q.elapsed + 7'd1;
							if (st_nx.elapsed >= st_q.active_period) begin
								// phase end: flip road, load the pending period
								st_nx.elapsed       = 7'd0;
								st_nx.amber         = 1'b0;
								st_nx.arrow         = 1'b0;
								st_nx.active_period = st_q.next_period;
								st_nx.phase_cnt     = st_q.next_period;
								st_nx.road          = ~st_q.road;
								st_nx.walk_cnt      = (st_q.next_period > cfg.walk_off) ?
									st_q.next_period - cfg.walk_off : 7'd0;
							end else begin
								if (st_q.phase_cnt != 7'd0)
									st_nx.phase_cnt = st_q.phase_cnt - 7'd1;
								if (st_q.walk_cnt != 7'd0)
									st_nx.walk_cnt = st_q.walk_cnt - 7'd1;
							end
							half = st_nx.active_period >> 1;
							if ((st_nx.active_period >= amb7 &&
									st_nx.elapsed == st_nx.active_period - amb7) ||
									(half >= amb7 && st_nx.elapsed == half - amb7))
								st_nx.amber = 1'b1;
							if (st_nx.elapsed == half) begin
								st_nx.arrow = 1'b1;
								st_nx.amber = 1'b0;
							end
						end
					end
				end
				KIND_LONGER: begin
					if (st_q.next_period < MaxPeriod)
						st_nx.next_period = st_q.next_period + 7'd1;
				end
				KIND_SHORTER: begin
					if (st_q.next_period > MIN_PERIOD)
						st_nx.next_period = st_q.next_period - 7'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.subtick       <= 8'd0;
			st_q.elapsed       <= 7'd0;
			st_q.active_period <= DefaultPeriod;
			st_q.next_period   <= DefaultPeriod;
			st_q.phase_cnt     <= DefaultPeriod;
			st_q.walk_cnt      <= ResetWalk;
			st_q.road          <= 1'b1;
			st_q.amber         <= 1'b0;
			st_q.arrow         <= 1'b0;
		end else begin
			st_q <= st_nx;
		end
	end

	`ASSERT_ALWAYS(a_elapsed_in_phase, st_q.elapsed < st_q.active_period, "elapsed past period")
	`ASSERT_ALWAYS(a_cnt_le_period, st_q.phase_cnt <= st_q.active_period, "countdown above period")
	`ASSERT_NEXT(a_idle_holds, !step, st_q == $past(st_q), "state moved without a request")

endmodule

/* src/tlpc_fmt.sv */
// ----------------------------------------------------------------------------
// tlpc_fmt
// lamp patterns, seven-segment digits and result packing
// ----------------------------------------------------------------------------
module tlpc_fmt
	import tlpc_pkg::*;
(
	input  tlpc_state_t          st,
	output logic [RESULT_W-1:0]  data
);

	logic [7:0] main_l;
	logic [7:0] aux_l;

	always_comb begin
		// amber wins over the arrow
		if (st.amber) begin
			main_l = st.road ? MAIN_AMBER_R1 : MAIN_AMBER_R0;
			aux_l  = st.road ? AUX_AMBER_R1 : AUX_AMBER_R0;
		end else if (st.road) begin
			main_l = st.arrow ? MAIN_ARROW_R1 : MAIN_PLAIN_R1;
			aux_l  = st.arrow ? AUX_ARROW_R1 : AUX_PLAIN_R1;
		end else begin
			main_l = st.arrow ? MAIN_ARROW_R0 : MAIN_PLAIN_R0;
			aux_l  = st.arrow ? AUX_ARROW_R0 : AUX_PLAIN_R0;
		end
	end

	assign data = {4'd0, st.next_period,
		seg_units(st.walk_cnt), seg_tens(st.walk_cnt),
		seg_units(st.phase_cnt), seg_tens(st.phase_cnt),
		st.walk_cnt, st.phase_cnt,
		st.arrow, st.amber, st.road, aux_l, main_l};

endmodule

/* tb/tb_traffic_light_phase_controller.sv */
// ----------------------------------------------------------------------------
// tb_traffic_light_phase_controller
// self-checking bench for the two-road light sequencer: requests go in on the
// slave stream, every result on the master stream is checked field by field
// against a local model of the phase timing, lamps and displays. timing
// registers are set and read back over apb between request bursts.
// ----------------------------------------------------------------------------
module tb_traffic_light_phase_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import tlpc_pkg::*;

	localparam logic [1:0] KIND_UNKNOWN  = 2'd3;
	localparam logic [1:0] REG_SPARE     = 2'd3;
	localparam logic [6:0] PERIOD_DEFAULT = 7'd20;
	localparam logic [6:0] PERIOD_MAX     = 7'd99;
	localparam int RESULT_LATENCY = 1;
	localparam int QUIET_LIMIT    = 2000;
	localparam int MAX_REPORTS    = 40;

	// one displayed state, msb first so it maps onto m_tdata[67:0]
	typedef struct packed {
		logic [6:0] pending_period;
		logic [6:0] seg_walk_units;
		logic [6:0] seg_walk_tens;
		logic [6:0] seg_time_units;
		logic [6:0] seg_time_tens;
		logic [6:0] walk_left;
		logic [6:0] seconds_left;
		logic       arrow_on;
		logic       amber_on;
		logic       direction;
		logic [7:0] aux_lamps;
		logic [7:0] main_lamps;
	} display_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;   // held[0], zeros[7:1]
	logic [1:0]          s_tuser = '0;   // kind[1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RESULT_W-1:0] m_tdata;        // see display_t, zeros[71:68]

	traffic_light_phase_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// timing registers as the block should hold them
	logic [7:0] cfg_tps;
	logic [3:0] cfg_amber;
	logic [6:0] cfg_walk_off;

	// light state
	logic [7:0] sub_count;
	logic [6:0] elapsed_s;
	logic [6:0] cur_period;
	logic [6:0] queued_period;
	logic [6:0] phase_left;
	logic [6:0] walk_s;
	logic       road;
	logic       amber;
	logic       arrow;

	display_t pending_displays[$];
	display_t got_display;
	display_t want_display;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int results_checked = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what);
		if (error_count < MAX_REPORTS)
			$display("[%0t] result %0d: %s", $time, results_checked, what);
		error_count++;
	endtask

	function automatic logic [6:0] walk_time(input logic [6:0] period);
		return (period > cfg_walk_off) ? period - cfg_walk_off : 7'd0;
	endfunction

	function automatic void load_reset_state();
		cfg_tps = RESET_TPS;
		cfg_amber = RESET_AMBER;
		cfg_walk_off = RESET_WALK_OFF;
		sub_count = '0;
		elapsed_s = '0;
		cur_period = PERIOD_DEFAULT;
		queued_period = PERIOD_DEFAULT;
		phase_left = PERIOD_DEFAULT;
		walk_s = walk_time(PERIOD_DEFAULT);
		road = 1'b1;
		amber = 1'b0;
		arrow = 1'b0;
	endfunction

	function automatic void count_tick();
		int per;
		int amb;
		int el;
		int half;
		// a lowered rate can leave the sub count above the new limit
		if (int'(sub_count) + 1 < int'(cfg_tps)) begin
			sub_count = sub_count + 8'd1;
			return;
		end
		sub_count = '0;
		elapsed_s = elapsed_s + 7'd1;
		if (elapsed_s >= cur_period) begin
			elapsed_s = '0;
			amber = 1'b0;
			arrow = 1'b0;
			cur_period = queued_period;
			phase_left = cur_period;
			road = ~road;
			walk_s = walk_time(cur_period);
		end else begin
			if (phase_left != 0)
				phase_left = phase_left - 7'd1;
			if (walk_s != 0)
				walk_s = walk_s - 7'd1;
		end
		per = cur_period;
		amb = cfg_amber;
		el = elapsed_s;
		half = per / 2;
		// an amber lead longer than the span is never reached
		if ((per >= amb && el == per - amb) || (half >= amb && el == half - amb))
			amber = 1'b1;
		if (el == half) begin
			arrow = 1'b1;
			amber = 1'b0;
		end
	endfunction

	function automatic logic [6:0] digit_segments(input int d);
		case (d)
			0: return 7'h3F;
			1: return 7'h06;
			2: return 7'h5B;
			3: return 7'h4F;
			4: return 7'h66;
			5: return 7'h6D;
			6: return 7'h7D;
			7: return 7'h07;
			8: return 7'h7F;
			default: return 7'h6F;
		endcase
	endfunction

	function automatic display_t predict_display(input logic [1:0] kind, input logic held);
		display_t d;
		case (kind)
			KIND_TICK: begin
				if (!held)
					count_tick();
			end
			KIND_LONGER: begin
				if (queued_period < PERIOD_MAX)
					queued_period = queued_period + 7'd1;
			end
			KIND_SHORTER: begin
				if (queued_period > MIN_PERIOD)
					queued_period = queued_period - 7'd1;
			end
			default: ;
		endcase
		if (amber) begin
			d.main_lamps = road ? MAIN_AMBER_R1 : MAIN_AMBER_R0;
			d.aux_lamps = road ? AUX_AMBER_R1 : AUX_AMBER_R0;
		end else if (road) begin
			d.main_lamps = arrow ? MAIN_ARROW_R1 : MAIN_PLAIN_R1;
			d.aux_lamps = arrow ? AUX_ARROW_R1 : AUX_PLAIN_R1;
		end else begin
			d.main_lamps = arrow ? MAIN_ARROW_R0 : MAIN_PLAIN_R0;
			d.aux_lamps = arrow ? AUX_ARROW_R0 : AUX_PLAIN_R0;
		end
		d.direction = road;
		d.amber_on = amber;
		d.arrow_on = arrow;
		d.seconds_left = phase_left;
		d.walk_left = walk_s;
		d.seg_time_tens = digit_segments((int'(phase_left) / 10) % 10);
		d.seg_time_units = digit_segments(int'(phase_left) % 10);
		d.seg_walk_tens = digit_segments((int'(walk_s) / 10) % 10);
		d.seg_walk_units = digit_segments(int'(walk_s) % 10);
		d.pending_period = queued_period;
		return d;
	endfunction

	// one request; s_tvalid stays high for a back-to-back follower
	task automatic send_request(input logic [1:0] kind, input logic held);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'b0, held};
		do @(posedge clk); while (!s_tready);
		pending_displays.push_back(predict_display(kind, held));
	endtask

	task automatic send_random_requests(input int count, input int longer_pct,
			input int shorter_pct);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < longer_pct)
				send_request(KIND_LONGER, 1'($urandom_range(0, 1)));
			else if (r < longer_pct + shorter_pct)
				send_request(KIND_SHORTER, 1'($urandom_range(0, 1)));
			else if (r < longer_pct + shorter_pct + 4)
				send_request(KIND_UNKNOWN, 1'($urandom_range(0, 1)));
			else
				send_request(KIND_TICK, $urandom_range(0, 99) < 10);
		end
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_displays.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TPS:      cfg_tps = value[7:0];
			REG_AMBER:    cfg_amber = value[3:0];
			REG_WALK_OFF: cfg_walk_off = value[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d read %0h expected %0h", idx, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper write bits are noise, the block keeps only the register width
	task automatic program_timing(input logic [7:0] tps, input logic [3:0] amber_s,
			input logic [6:0] walk_off);
		logic [31:0] noise;
		wait_for_results();
		noise = $urandom();
		apb_write(REG_TPS, {noise[31:8], tps});
		noise = $urandom();
		apb_write(REG_AMBER, {noise[31:4], amber_s});
		noise = $urandom();
		apb_write(REG_WALK_OFF, {noise[31:7], walk_off});
		apb_read_check(REG_TPS, {24'b0, cfg_tps});
		apb_read_check(REG_AMBER, {28'b0, cfg_amber});
		apb_read_check(REG_WALK_OFF, {25'b0, cfg_walk_off});
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	task automatic test_directed_corners();
		send_request(KIND_UNKNOWN, 1'b0);
		send_request(KIND_UNKNOWN, 1'b1);
		send_request(KIND_TICK, 1'b1);
		send_request(KIND_TICK, 1'b0);
		send_request(KIND_LONGER, 1'b1);
		send_request(KIND_SHORTER, 1'b0);
		// zero tick rate, walk offset no smaller than any period
		program_timing(8'd0, 4'd3, 7'd99);
		apb_write(REG_SPARE, 32'hFFFF_FFFF);
		// down to the floor and one press past it
		repeat (11)
			send_request(KIND_SHORTER, 1'($urandom_range(0, 1)));
		repeat (6)
			send_request(KIND_TICK, 1'b0);
	endtask

	task automatic test_period_limits();
		program_timing(8'd1, 4'd2, 7'd0);
		send_random_requests(130, 90, 0);
		send_random_requests(130, 0, 90);
	endtask

	task automatic test_amber_and_arrow();
		program_timing(8'd1, 4'd3, 7'd10);
		send_random_requests(160, 9, 9);
		program_timing(8'd2, 4'd9, 7'd0);
		send_random_requests(160, 9, 9);
		program_timing(8'd1, 4'd1, 7'd20);
		send_random_requests(160, 9, 9);
	endtask

	task automatic test_tick_rates();
		program_timing(8'd0, 4'd0, 7'd99);
		send_random_requests(160, 9, 9);
		program_timing(8'd255, 4'd5, 7'd30);
		send_random_requests(150, 9, 9);
		// sub count is well above the new rate here
		program_timing(8'd4, 4'd4, 7'd50);
		send_random_requests(160, 9, 9);
	endtask

	task automatic test_walk_offsets();
		program_timing(8'd3, 4'd15, 7'd127);
		send_random_requests(160, 9, 9);
		program_timing(8'd1, 4'd6, 7'd64);
		send_random_requests(160, 9, 9);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_displays.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				got_display = display_t'(m_tdata[67:0]);
				want_display = pending_displays.pop_front();
				check_field("main_lamps", got_display.main_lamps, want_display.main_lamps);
				check_field("aux_lamps", got_display.aux_lamps, want_display.aux_lamps);
				check_field("direction", got_display.direction, want_display.direction);
				check_field("amber_on", got_display.amber_on, want_display.amber_on);
				check_field("arrow_on", got_display.arrow_on, want_display.arrow_on);
				check_field("seconds_left", got_display.seconds_left,
					want_display.seconds_left);
				check_field("walk_left", got_display.walk_left, want_display.walk_left);
				check_field("seg_time_tens", got_display.seg_time_tens,
					want_display.seg_time_tens);
				check_field("seg_time_units", got_display.seg_time_units,
					want_display.seg_time_units);
				check_field("seg_walk_tens", got_display.seg_walk_tens,
					want_display.seg_walk_tens);
				check_field("seg_walk_units", got_display.seg_walk_units,
					want_display.seg_walk_units);
				check_field("pending_period", got_display.pending_period,
					want_display.pending_period);
			end
			results_checked++;
		end
	end

	// ends a hung run: no request, result or register access for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_traffic_light_phase_controller: done, errors");
			$finish;
		end
	end

	initial begin
		load_reset_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(29, 76);
		test_directed_corners();
		test_period_limits();
		test_amber_and_arrow();
		set_idling(76, 29);
		test_tick_rates();
		set_idling(0, 0);
		test_walk_offsets();
		wait_for_results();
		repeat (RESULT_LATENCY * 4) @(posedge clk);
		if (error_count == 0)
			$display("tb_traffic_light_phase_controller: done, clean");
		else
			$display("tb_traffic_light_phase_controller: done, errors");
		$finish;
	end

endmodule

/* traffic_light_phase_controller.f */
+incdir+src
src/tlpc_pkg.sv
src/tlpc_regs.sv
src/tlpc_seq.sv
src/tlpc_fmt.sv
src/traffic_light_phase_controller.sv
tb/tb_traffic_light_phase_controller.sv
